// File: hw/rtl/bst_pkg.sv
// ---------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the byte stream tokenizer.
// ---------------------------------------------------------------------------
package bst_pkg;

   // default of the word buffer depth
   localparam int MAX_WORD_DEFAULT = 32;
   // word count field wide enough for counts up to 127
   localparam int LEN_W = 7;
   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // token kinds
   localparam logic [2:0] KIND_INT  = 3'd0;
   localparam logic [2:0] KIND_KEY  = 3'd1;
   localparam logic [2:0] KIND_WORD = 3'd2;
   localparam logic [2:0] KIND_SEP  = 3'd3;
   localparam logic [2:0] KIND_OP   = 3'd4;
   localparam logic [2:0] KIND_EOF  = 3'd5;
   localparam logic [2:0] KIND_ERR  = 3'd6;

   // flush operations carried by a command
   localparam logic [1:0] FLUSH_NONE = 2'd0;
   localparam logic [1:0] FLUSH_INT  = 2'd1;
   localparam logic [1:0] FLUSH_WORD = 2'd2;

   // configuration register indexes
   localparam logic CSR_KEYWORD_CHARS  = 1'b0;
   localparam logic CSR_KEYWORD_LENGTH = 1'b1;

   // register reset values
   localparam logic [31:0] KEYWORD_CHARS_RESET  = 32'h6578_6974;
   localparam logic [2:0]  KEYWORD_LENGTH_RESET = 3'd4;

   // character codes
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   // saturation limit of integer tokens
   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

   // one queued command: an optional flush and an optional own result
   typedef struct packed {
      logic [1:0]       flush_op;
      logic [30:0]      number;
      logic [LEN_W-1:0] word_cnt;
      logic             word_cut;
      logic             keyword;
      logic             own_valid;
      logic [2:0]       own_kind;
      logic [7:0]       own_char;
   } cmd_type;

   // status of the command queue seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: hw/rtl/bst_queue.sv
// ---------------------------------------------------------------------------
// bst_queue
// Short command queue that decouples the classifying front from the back.
// ---------------------------------------------------------------------------
module bst_queue
   import bst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output cmd_type          head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/bst_front.sv
// ---------------------------------------------------------------------------
// bst_front
// Accepts source bytes, classifies them, keeps the pending run and queues
// one command per byte that causes results.
// ---------------------------------------------------------------------------
module bst_front
   import bst_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEFAULT,
   localparam int IDX_W = $clog2(MAX_WORD)
) (
   input  logic             clock,
   input  logic             reset,
   // source channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tuser,
   // configuration
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   // command queue
   input  queue_status_type q_status,
   output logic             q_push,
   output cmd_type          q_data,
   // word buffer write port
   output logic             wbuf_we,
   output logic [IDX_W-1:0] wbuf_addr,
   output logic [7:0]       wbuf_data,
   // back has emitted the last character of a word
   input  logic             word_done
);

   localparam int CNT_W = $clog2(MAX_WORD + 1);

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_NUM  = 2'd1;
   localparam logic [1:0] MODE_WORD = 2'd2;

   logic [31:0]      kw_chars_ff;
   logic [2:0]       kw_len_ff;
   logic [1:0]       mode_ff, mode_in;
   logic [30:0]      acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             match_ff, match_in;
   logic             halted_ff, halted_in;
   logic             word_pend_ff, word_pend_in;

   logic             accept;
   logic [7:0]       b;
   logic             eoi;
   logic             is_digit, is_letter, is_space, is_sep, is_op, is_err;
   logic             need_flush;
   logic [1:0]       flush_op;
   logic             own_valid;
   logic [2:0]       own_kind;
   logic [7:0]       own_char;
   logic             keyword;
   logic [30:0]      acc_base;
   logic [CNT_W-1:0] cnt_base;
   logic             ovf_base, match_base;
   logic [34:0]      acc_prod;
   logic [7:0]       kw_char;

   assign req_tready = !word_pend_ff && !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign eoi        = req_tuser;

   // byte classes
   assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
   assign is_letter = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
                      ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
   assign is_space  = (b == CH_SPACE) || (b == CH_NL);
   assign is_sep    = (b == CH_SEMI) || (b == CH_LPAREN) || (b == CH_RPAREN);
   assign is_op     = (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_SLASH) ||
                      (b == CH_STAR);
   assign is_err    = !is_digit && !is_letter && !is_space && !is_sep && !is_op;

   // a byte that does not continue the pending run flushes it
   assign need_flush = eoi || (is_digit && (mode_ff != MODE_NUM)) ||
                       (is_letter && (mode_ff != MODE_WORD)) ||
                       (!is_digit && !is_letter);

   always_comb begin
      flush_op = FLUSH_NONE;
      if (need_flush) begin
         case (mode_ff)
            MODE_NUM:  flush_op = FLUSH_INT;
            MODE_WORD: flush_op = FLUSH_WORD;
            default:   flush_op = FLUSH_NONE;
         endcase
      end
   end

   // own result of the byte
   always_comb begin
      own_valid = 1'b1;
      own_kind  = KIND_EOF;
      own_char  = 8'd0;
      if (eoi) begin
         own_kind = KIND_EOF;
      end else if (is_sep) begin
         own_kind = KIND_SEP;
         own_char = b;
      end else if (is_op) begin
         own_kind = KIND_OP;
         own_char = b;
      end else if (is_err) begin
         own_kind = KIND_ERR;
         own_char = b;
      end else begin
         own_valid = 1'b0;
      end
   end

   // keyword test of the pending word
   assign keyword = match_ff && !ovf_ff && (kw_len_ff >= 3'd1) && (kw_len_ff <= 3'd4) &&
                    (LEN_W'(cnt_ff) == LEN_W'(kw_len_ff));

   // command to the queue
   always_comb begin
      q_data.flush_op  = flush_op;
      q_data.number    = acc_ff;
      q_data.word_cnt  = LEN_W'(cnt_ff);
      q_data.word_cut  = ovf_ff;
      q_data.keyword   = keyword;
      q_data.own_valid = own_valid;
      q_data.own_kind  = own_kind;
      q_data.own_char  = own_char;
   end
   assign q_push = accept && !halted_ff && ((flush_op != FLUSH_NONE) || own_valid);

   // run state after an optional flush
   assign acc_base   = need_flush ? '0 : acc_ff;
   assign cnt_base   = need_flush ? '0 : cnt_ff;
   assign ovf_base   = need_flush ? 1'b0 : ovf_ff;
   assign match_base = need_flush ? 1'b1 : match_ff;

   // accumulator times ten plus digit
   assign acc_prod = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                     {31'd0, b[3:0]};

   // keyword character at the next word position
   always_comb begin
      case (cnt_base[1:0])
         2'd0:    kw_char = kw_chars_ff[31:24];
         2'd1:    kw_char = kw_chars_ff[23:16];
         2'd2:    kw_char = kw_chars_ff[15:8];
         default: kw_char = kw_chars_ff[7:0];
      endcase
   end

   // next run state
   always_comb begin
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      match_in     = match_ff;
      halted_in    = halted_ff;
      word_pend_in = word_pend_ff && !word_done;
      wbuf_we      = 1'b0;
      wbuf_addr    = cnt_base[IDX_W-1:0];
      wbuf_data    = b;
      if (accept && !halted_ff) begin
         mode_in  = MODE_IDLE;
         acc_in   = acc_base;
         cnt_in   = cnt_base;
         ovf_in   = ovf_base;
         match_in = match_base;
         if (flush_op == FLUSH_WORD) begin
            word_pend_in = 1'b1;
         end
         if (!eoi && is_digit) begin
            mode_in = MODE_NUM;
            acc_in  = (acc_prod[34:31] != 4'd0) ? NUM_MAX : acc_prod[30:0];
         end else if (!eoi && is_letter) begin
            mode_in = MODE_WORD;
            if (cnt_base < CNT_W'(MAX_WORD)) begin
               wbuf_we = 1'b1;
               cnt_in  = cnt_base + 1'b1;
               if (cnt_base < CNT_W'(4)) begin
                  match_in = match_base && (b == kw_char);
               end
            end else begin
               ovf_in = 1'b1;
            end
         end else if (!eoi && is_err) begin
            halted_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         match_ff     <= 1'b1;
         halted_ff    <= 1'b0;
         word_pend_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         match_ff     <= match_in;
         halted_ff    <= halted_in;
         word_pend_ff <= word_pend_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_chars_ff <= KEYWORD_CHARS_RESET;
         kw_len_ff   <= KEYWORD_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEYWORD_CHARS:  kw_chars_ff <= csr_wdata;
            CSR_KEYWORD_LENGTH: kw_len_ff   <= csr_wdata[2:0];
            default:            kw_len_ff   <= kw_len_ff;
         endcase
      end
   end

endmodule

// File: hw/rtl/bst_back.sv
// ---------------------------------------------------------------------------
// bst_back
// Carries out queued commands: emits flushed tokens, walks the word buffer
// one character per result, then the byte's own result.
// ---------------------------------------------------------------------------
module bst_back
   import bst_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEFAULT,
   localparam int IDX_W = $clog2(MAX_WORD)
) (
   input  logic             clock,
   input  logic             reset,
   // command queue
   input  queue_status_type q_status,
   input  cmd_type          q_head,
   output logic             q_pop,
   // word buffer write port
   input  logic             wbuf_we,
   input  logic [IDX_W-1:0] wbuf_addr,
   input  logic [7:0]       wbuf_data,
   output logic             word_done,
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tdata fields from bit 0: token_kind[2:0], number_value[30:0],
   // char_code[7:0], word_length[5:0], word_cut, zero fill to 56 bits
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_WORD + 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_WORD = 2'd2;
   localparam logic [1:0] PH_OWN  = 2'd3;

   logic [7:0]       wbuf_mem [MAX_WORD];
   logic [7:0]       rd_data_ff;

   logic [1:0]       phase_ff, phase_in;
   cmd_type          cur_ff, cur_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff, rsp_kind_in;
   logic [30:0]      rsp_value_ff, rsp_value_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [5:0]       rsp_len_ff, rsp_len_in;
   logic             rsp_cut_ff, rsp_cut_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             load;
   logic             last_char;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_char = ((idx_ff + 1'b1) == cur_ff.word_cnt[CNT_W-1:0]);

   // command sequencing
   always_comb begin
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      word_done    = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_cut_in   = rsp_cut_ff;
      rsp_last_in  = rsp_last_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (!q_status.empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               idx_in = '0;
               case (q_head.flush_op)
                  FLUSH_INT:  phase_in = PH_INT;
                  FLUSH_WORD: phase_in = PH_WORD;
                  default:    phase_in = PH_OWN;
               endcase
            end
         end
         PH_INT: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_kind_in  = KIND_INT;
               rsp_value_in = cur_ff.number;
               rsp_char_in  = 8'd0;
               rsp_len_in   = 6'd0;
               rsp_cut_in   = 1'b0;
               rsp_last_in  = !cur_ff.own_valid;
               phase_in     = cur_ff.own_valid ? PH_OWN : PH_IDLE;
            end
         end
         PH_WORD: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_kind_in  = cur_ff.keyword ? KIND_KEY : KIND_WORD;
               rsp_value_in = '0;
               rsp_char_in  = rd_data_ff;
               rsp_len_in   = cur_ff.word_cnt[5:0];
               rsp_cut_in   = cur_ff.word_cut;
               rsp_last_in  = last_char && !cur_ff.own_valid;
               if (last_char) begin
                  word_done = 1'b1;
                  phase_in  = cur_ff.own_valid ? PH_OWN : PH_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_kind_in  = cur_ff.own_kind;
               rsp_value_in = '0;
               rsp_char_in  = cur_ff.own_char;
               rsp_len_in   = 6'd0;
               rsp_cut_in   = 1'b0;
               rsp_last_in  = 1'b1;
               phase_in     = PH_IDLE;
            end
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // current command and result payload
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_cut_ff   <= rsp_cut_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // word buffer, read data follows the next index
   always_ff @(posedge clock) begin
      if (wbuf_we) begin
         wbuf_mem[wbuf_addr] <= wbuf_data;
      end
      rd_data_ff <= wbuf_mem[idx_in[IDX_W-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_cut_ff, rsp_len_ff, rsp_char_ff, rsp_value_ff,
                        rsp_kind_ff};

endmodule

// File: hw/rtl/byte_stream_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// byte_stream_tokenizer_unit
// Splits a byte stream into integer, keyword, word, separator, operator,
// end-of-file and error tokens.
// ---------------------------------------------------------------------------
// Throughput: one source byte per cycle while bytes only extend a run and the
// queue has room; a byte that causes results queues a command, which the back
// takes while idle before it emits each result, holding while the output stalls.
// A word flush stalls input until the back has walked the word buffer.
// Path: a command passes the queue entry, the back's current command and the result register.
// Reset: synchronous; clears run state, queue, halt flag and registers.
// ---------------------------------------------------------------------------
module byte_stream_tokenizer_unit
   import bst_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // source channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata fields from bit 0: source_byte[7:0]
   input  logic [7:0]  req_tdata,
   // tuser fields from bit 0: end_of_input
   input  logic        req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata fields from bit 0: token_kind[2:0], number_value[30:0],
   // char_code[7:0], word_length[5:0], word_cut, zero fill to 56 bits
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_WORD);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   cmd_type          q_data;
   cmd_type          q_head;
   logic             wbuf_we;
   logic [IDX_W-1:0] wbuf_addr;
   logic [7:0]       wbuf_data;
   logic             word_done;

   // classifying front
   bst_front #(
      .MAX_WORD (MAX_WORD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_data),
      .wbuf_we    (wbuf_we),
      .wbuf_addr  (wbuf_addr),
      .wbuf_data  (wbuf_data),
      .word_done  (word_done)
   );

   // command queue
   bst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // emitting back
   bst_back #(
      .MAX_WORD (MAX_WORD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .wbuf_we    (wbuf_we),
      .wbuf_addr  (wbuf_addr),
      .wbuf_data  (wbuf_data),
      .word_done  (word_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
